// File: hw/rtl/udp_hb_pkg.sv
// shared types and constants for the udp/ipv4 frame header builder
// no dependencies; imported by every module of the block

package udp_hb_pkg;

   localparam int unsigned MAX_PAYLOAD_BYTES = 1472;

   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned WIDE_W   = 12;
   localparam int unsigned RAW_W    = 20;
   localparam int unsigned WORD_CNT = 21;
   localparam int unsigned IDX_W    = 5;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [WIDE_W-1:0]  MAX_BYTES = WIDE_W'(MAX_PAYLOAD_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_CAP = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_MAC  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_IP   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVER_PORT = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIENT_PORT = 8'd3;

   localparam logic [15:0] SERVER_PORT_RESET = 16'd67;
   localparam logic [15:0] CLIENT_PORT_RESET = 16'd68;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_HW  = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   // fixed header words
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] IP_VER_IHL     = 16'h4500;
   localparam logic [15:0] IP_ID          = 16'h0000;
   localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
   localparam logic [15:0] IP_TTL_PROTO   = 16'h4011;
   localparam logic [15:0] UDP_PROTO      = 16'd17;
   localparam logic [WIDE_W-1:0] IP_HDR_BYTES  = 12'd28;
   localparam logic [WIDE_W-1:0] UDP_HDR_BYTES = 12'd8;

   localparam logic [7:0] HW_TYPE_ETHER = 8'd1;
   localparam logic [7:0] HW_LEN_ETHER  = 8'd6;

   typedef struct packed {
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [15:0] server_port;
      logic [15:0] client_port;
   } cfg_type;

   // one finished packet, handed from accumulator to emitter
   typedef struct packed {
      logic [47:0]        dest_mac;
      logic [31:0]        dest_ip;
      logic [COUNT_W-1:0] byte_count;
      logic [15:0]        sum;
      logic [1:0]         status;
   } job_type;

   // fold a 20-bit raw sum to 16 bits and finish as an internet checksum
   function automatic logic [15:0] finish_sum(input logic [RAW_W-1:0] raw);
      logic [16:0] a;
      logic [15:0] b;
      a = {1'b0, raw[15:0]} + {13'd0, raw[19:16]};
      b = a[15:0] + {15'd0, a[16]};
      return (b == 16'hffff) ? 16'hffff : ~b;
   endfunction

endpackage

// File: hw/rtl/udp_hb_csr.sv
// configuration registers of the header builder
// depends on udp_hb_pkg

module udp_hb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [udp_hb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [udp_hb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output udp_hb_pkg::cfg_type                cfg
);
   import udp_hb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_MAC:  cfg_in.source_mac  = csr_wdata;
            CSR_SOURCE_IP:   cfg_in.source_ip   = csr_wdata[31:0];
            CSR_SERVER_PORT: cfg_in.server_port = csr_wdata[15:0];
            CSR_CLIENT_PORT: cfg_in.client_port = csr_wdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_mac  <= '0;
         cfg_ff.source_ip   <= '0;
         cfg_ff.server_port <= SERVER_PORT_RESET;
         cfg_ff.client_port <= CLIENT_PORT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/udp_hb_acc.sv
// payload accumulator: ones-complement sum, byte count, per-packet sampling
// depends on udp_hb_pkg; feeds one job per packet to the emitter

module udp_hb_acc (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [15:0]         req_payload_word,
   input  logic                req_odd_tail,
   input  logic                req_last,
   input  logic [47:0]         req_client_mac,
   input  logic [31:0]         req_client_ip,
   input  logic                req_broadcast,
   input  logic [7:0]          req_hw_type,
   input  logic [7:0]          req_hw_len,
   output logic                job_valid,
   output udp_hb_pkg::job_type job,
   input  logic                job_taken
);
   import udp_hb_pkg::*;

   logic [15:0]        sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               open_ff, open_in;
   logic [47:0]        dmac_ff, dmac_in;
   logic [31:0]        dip_ff, dip_in;
   logic               hwok_ff, hwok_in;
   logic               long_ff, long_in;
   logic               job_valid_ff, job_valid_in;
   job_type            job_ff, job_in;

   logic               accept;
   logic               tail;
   logic [15:0]        word_eff;
   logic [16:0]        sum_wide;
   logic [15:0]        sum_new;
   logic [WIDE_W-1:0]  cnt;
   logic               long_new;
   logic [COUNT_W-1:0] count_new;
   logic [47:0]        dmac_cur;
   logic [31:0]        dip_cur;
   logic               hwok_cur;

   // a last beat waits while the previous job is still unclaimed
   assign req_stall = req_last & job_valid_ff;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      // first beat of a packet samples the addressing
      if (open_ff) begin
         dmac_cur = dmac_ff;
         dip_cur  = dip_ff;
         hwok_cur = hwok_ff;
      end else begin
         dmac_cur = req_broadcast ? '1 : req_client_mac;
         dip_cur  = req_broadcast ? '1 : req_client_ip;
         hwok_cur = (req_hw_type == HW_TYPE_ETHER) && (req_hw_len == HW_LEN_ETHER);
      end

      tail      = req_last & req_odd_tail;
      word_eff  = tail ? {req_payload_word[15:8], 8'h00} : req_payload_word;
      sum_wide  = {1'b0, sum_ff} + {1'b0, word_eff};
      sum_new   = sum_wide[15:0] + {15'd0, sum_wide[16]};
      cnt       = {1'b0, count_ff} + (tail ? 12'd1 : 12'd2);
      long_new  = long_ff | (cnt > MAX_BYTES);
      count_new = (cnt > {1'b0, COUNT_CAP}) ? COUNT_CAP : cnt[COUNT_W-1:0];

      sum_in   = sum_ff;
      count_in = count_ff;
      open_in  = open_ff;
      dmac_in  = dmac_ff;
      dip_in   = dip_ff;
      hwok_in  = hwok_ff;
      long_in  = long_ff;
      job_in   = job_ff;
      job_valid_in = job_valid_ff & ~job_taken;

      if (accept) begin
         if (req_last) begin
            sum_in   = '0;
            count_in = '0;
            open_in  = 1'b0;
            long_in  = 1'b0;
            job_valid_in      = 1'b1;
            job_in.dest_mac   = dmac_cur;
            job_in.dest_ip    = dip_cur;
            job_in.byte_count = count_new;
            job_in.sum        = sum_new;
            if (!hwok_cur) begin
               job_in.status = STATUS_BAD_HW;
            end else if (long_new) begin
               job_in.status = STATUS_TOO_LONG;
            end else begin
               job_in.status = STATUS_OK;
            end
         end else begin
            sum_in   = sum_new;
            count_in = count_new;
            open_in  = 1'b1;
            long_in  = long_new;
         end
         dmac_in = dmac_cur;
         dip_in  = dip_cur;
         hwok_in = hwok_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         open_ff      <= 1'b0;
         dmac_ff      <= '0;
         dip_ff       <= '0;
         hwok_ff      <= 1'b0;
         long_ff      <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         open_ff      <= open_in;
         dmac_ff      <= dmac_in;
         dip_ff       <= dip_in;
         hwok_ff      <= hwok_in;
         long_ff      <= long_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

// File: hw/rtl/udp_hb_emit.sv
// header emitter: raw checksum sums on job load, then one header word per beat
// depends on udp_hb_pkg; drives the registered result channel

module udp_hb_emit (
   input  logic                clock,
   input  logic                reset,
   input  udp_hb_pkg::cfg_type cfg,
   input  logic                job_valid,
   input  udp_hb_pkg::job_type job,
   output logic                job_taken,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_header_word,
   output logic [1:0]          rsp_status,
   output logic                rsp_end_of_header
);
   import udp_hb_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_CNT - 1);

   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [47:0]        dmac_ff, dmac_in;
   logic [31:0]        dip_ff, dip_in;
   logic [WIDE_W-1:0]  ip_len_ff, ip_len_in;
   logic [WIDE_W-1:0]  udp_len_ff, udp_len_in;
   logic [RAW_W-1:0]   ip_raw_ff, ip_raw_in;
   logic [RAW_W-1:0]   udp_raw_ff, udp_raw_in;
   logic [1:0]         status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_word_ff, rsp_word_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_eoh_ff, rsp_eoh_in;

   logic               advance;
   logic               is_err;
   logic [WIDE_W-1:0]  job_ip_len;
   logic [WIDE_W-1:0]  job_udp_len;
   logic [RAW_W-1:0]   addr_sum;
   logic [15:0]        sel_word;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign job_taken = ~busy_ff & job_valid;
   assign is_err    = (status_ff != STATUS_OK);

   // address words shared by both checksums
   assign job_ip_len  = IP_HDR_BYTES + {1'b0, job.byte_count};
   assign job_udp_len = UDP_HDR_BYTES + {1'b0, job.byte_count};
   assign addr_sum = RAW_W'(cfg.source_ip[31:16]) + RAW_W'(cfg.source_ip[15:0])
                   + RAW_W'(job.dest_ip[31:16]) + RAW_W'(job.dest_ip[15:0]);

   always_comb begin
      case (idx_ff)
         5'd0:    sel_word = dmac_ff[47:32];
         5'd1:    sel_word = dmac_ff[31:16];
         5'd2:    sel_word = dmac_ff[15:0];
         5'd3:    sel_word = cfg.source_mac[47:32];
         5'd4:    sel_word = cfg.source_mac[31:16];
         5'd5:    sel_word = cfg.source_mac[15:0];
         5'd6:    sel_word = ETHERTYPE_IPV4;
         5'd7:    sel_word = IP_VER_IHL;
         5'd8:    sel_word = 16'(ip_len_ff);
         5'd9:    sel_word = IP_ID;
         5'd10:   sel_word = IP_FLAGS_DF;
         5'd11:   sel_word = IP_TTL_PROTO;
         5'd12:   sel_word = finish_sum(ip_raw_ff);
         5'd13:   sel_word = cfg.source_ip[31:16];
         5'd14:   sel_word = cfg.source_ip[15:0];
         5'd15:   sel_word = dip_ff[31:16];
         5'd16:   sel_word = dip_ff[15:0];
         5'd17:   sel_word = cfg.server_port;
         5'd18:   sel_word = cfg.client_port;
         5'd19:   sel_word = 16'(udp_len_ff);
         5'd20:   sel_word = finish_sum(udp_raw_ff);
         default: sel_word = 16'h0000;
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      dmac_in    = dmac_ff;
      dip_in     = dip_ff;
      ip_len_in  = ip_len_ff;
      udp_len_in = udp_len_ff;
      ip_raw_in  = ip_raw_ff;
      udp_raw_in = udp_raw_ff;
      status_in  = status_ff;

      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_eoh_in    = rsp_eoh_ff;

      if (job_taken) begin
         busy_in    = 1'b1;
         idx_in     = '0;
         dmac_in    = job.dest_mac;
         dip_in     = job.dest_ip;
         ip_len_in  = job_ip_len;
         udp_len_in = job_udp_len;
         status_in  = job.status;
         ip_raw_in  = RAW_W'(IP_VER_IHL) + RAW_W'(job_ip_len) + RAW_W'(IP_FLAGS_DF)
                    + RAW_W'(IP_TTL_PROTO) + addr_sum;
         udp_raw_in = RAW_W'(job_udp_len) + RAW_W'(job_udp_len) + RAW_W'(UDP_PROTO)
                    + RAW_W'(cfg.server_port) + RAW_W'(cfg.client_port)
                    + RAW_W'(job.sum) + addr_sum;
      end

      if (advance) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            if (is_err) begin
               rsp_word_in   = 16'h0000;
               rsp_status_in = status_ff;
               rsp_eoh_in    = 1'b1;
               busy_in       = 1'b0;
            end else begin
               rsp_word_in   = sel_word;
               rsp_status_in = STATUS_OK;
               rsp_eoh_in    = (idx_ff == LAST_IDX);
               idx_in        = idx_ff + 1'b1;
               busy_in       = (idx_ff != LAST_IDX);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dmac_ff       <= dmac_in;
      dip_ff        <= dip_in;
      ip_len_ff     <= ip_len_in;
      udp_len_ff    <= udp_len_in;
      ip_raw_ff     <= ip_raw_in;
      udp_raw_ff    <= udp_raw_in;
      status_ff     <= status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_eoh_ff    <= rsp_eoh_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_header_word   = rsp_word_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_end_of_header = rsp_eoh_ff;

endmodule

// File: hw/rtl/udp_ipv4_frame_header_builder_top.sv
// top level of the udp/ipv4 frame header builder
// depends on udp_hb_pkg, udp_hb_csr, udp_hb_acc and udp_hb_emit

// Payload beats (16-bit words, first byte in the upper half) are taken at one
// per cycle, but for a last beat held off by req_stall; the first beat of a
// packet samples client mac, client ip, the broadcast flag and the hardware
// type and length. Each beat is folded into a ones-complement sum and a
// saturating byte count. The beat marked last closes the packet and hands it
// to the emitter, which sends 21 header beats (ethernet, ipv4 with DF, ttl 64
// and header checksum, udp with pseudo-header checksum) at one per cycle while
// rsp_stall is low, or a single error beat (header_word 0, end_of_header 1)
// for non-ethernet hardware or an oversize payload. Payload beats of the next
// packet keep flowing while a header burst is out; only its last beat is held
// off (req_stall) while a finished packet still waits for the emitter.
// Registers are read when the header is built and are to be written only
// while the block is idle.

module udp_ipv4_frame_header_builder_top (
   input  logic                               clock,
   input  logic                               reset,
   // payload channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [15:0]                        req_payload_word,
   input  logic                               req_odd_tail,
   input  logic                               req_last,
   input  logic [47:0]                        req_client_mac,
   input  logic [31:0]                        req_client_ip,
   input  logic                               req_broadcast,
   input  logic [7:0]                         req_hw_type,
   input  logic [7:0]                         req_hw_len,
   // header channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [15:0]                        rsp_header_word,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_end_of_header,
   // register write port
   input  logic                               csr_write,
   input  logic [udp_hb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [udp_hb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import udp_hb_pkg::*;

   cfg_type cfg;
   job_type job;
   logic    job_valid;
   logic    job_taken;

   // register file
   udp_hb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // per-beat sum and count, one job per packet
   udp_hb_acc u_acc (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_word (req_payload_word),
      .req_odd_tail     (req_odd_tail),
      .req_last         (req_last),
      .req_client_mac   (req_client_mac),
      .req_client_ip    (req_client_ip),
      .req_broadcast    (req_broadcast),
      .req_hw_type      (req_hw_type),
      .req_hw_len       (req_hw_len),
      .job_valid        (job_valid),
      .job              (job),
      .job_taken        (job_taken)
   );

   // checksum sums and header burst
   udp_hb_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .job_valid         (job_valid),
      .job               (job),
      .job_taken         (job_taken),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_header_word   (rsp_header_word),
      .rsp_status        (rsp_status),
      .rsp_end_of_header (rsp_end_of_header)
   );

endmodule
